// ===== design/rmis_pkg.sv =====
package rmis_pkg;

    localparam logic [15:0] STEP_LIMIT_RESET = 16'd64;
    localparam logic [15:0] SEG_WRAP         = 16'h1000;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

    localparam logic [7:0] OP_ESCAPE   = 8'h0F;
    localparam logic [7:0] OP_INC_LO   = 8'h40;
    localparam logic [7:0] OP_INC_HI   = 8'h47;
    localparam logic [7:0] OP_DEC_LO   = 8'h48;
    localparam logic [7:0] OP_DEC_HI   = 8'h4F;
    localparam logic [7:0] OP_PUSH_LO  = 8'h50;
    localparam logic [7:0] OP_PUSH_HI  = 8'h57;
    localparam logic [7:0] OP_MOV_FROM_SREG = 8'h8C;
    localparam logic [7:0] OP_MOV_TO_SREG   = 8'h8E;
    localparam logic [7:0] OP_MOV_IMM_LO = 8'hB8;
    localparam logic [7:0] OP_MOV_IMM_HI = 8'hBF;
    localparam logic [7:0] OP_INT3     = 8'hCC;
    localparam logic [7:0] OP_INT      = 8'hCD;
    localparam logic [7:0] OP_IRET     = 8'hCF;
    localparam logic [7:0] OP_HLT      = 8'hF4;
    localparam logic [7:0] OP_GROUP5   = 8'hFF;

    localparam logic [7:0] ROM_SEL_LO    = 8'h1A;
    localparam logic [7:0] ROM_SEL_HI    = 8'h1E;
    localparam logic [7:0] ROM_SEL_VIDEO = 8'h2A;
    localparam logic [7:0] ROM_CODE_VIDEO = 8'd5;
    localparam logic [7:0] ROM_CODE_HALT  = 8'd1;
    localparam logic [7:0] VECTOR_BREAK   = 8'd3;
    localparam logic [4:0] GROUP5_JMP_REG = 5'b11100;
    localparam logic [1:0] MOD_REGISTER   = 2'b11;

    localparam logic [2:0] REG_SP = 3'd4;
    localparam logic [1:0] SREG_CS = 2'd1;
    localparam logic [1:0] SREG_SS = 2'd2;

    typedef enum logic [1:0] {
        SVC_NONE = 2'd0,
        SVC_INT  = 2'd1,
        SVC_IRET = 2'd2,
        SVC_ROM  = 2'd3
    } service_t;

    typedef enum logic [1:0] {
        STOP_RUN   = 2'd0,
        STOP_HALT  = 2'd1,
        STOP_TRAP  = 2'd2,
        STOP_LIMIT = 2'd3
    } stop_t;

    typedef logic [15:0] gen_regs_t [8];
    typedef logic [15:0] seg_regs_t [4];

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic       trap_flag;
    } instr_t;

    typedef struct packed {
        service_t    service;
        logic [7:0]  service_code;
        stop_t       stop;
        logic        mem_write;
        logic [20:0] write_address;
        logic [15:0] write_data;
        logic [20:0] fetch_address;
    } result_t;

    function automatic logic [20:0] phys(input logic [15:0] seg, input logic [15:0] off);
        phys = {1'b0, seg, 4'b0000} + {5'b00000, off};
    endfunction

endpackage

// ===== design/rmis_exec.sv =====
module rmis_exec (
    input  rmis_pkg::instr_t    instr,
    input  rmis_pkg::gen_regs_t gen_cur,
    input  rmis_pkg::seg_regs_t seg_cur,
    input  logic [15:0]         ip_cur,
    input  logic [15:0]         count_cur,
    input  logic [15:0]         step_limit,
    output rmis_pkg::gen_regs_t gen_next,
    output rmis_pkg::seg_regs_t seg_next,
    output logic [15:0]         ip_next,
    output logic [15:0]         count_next,
    output rmis_pkg::result_t   result
);
    import rmis_pkg::*;

    logic [2:0]  rm;
    logic [2:0]  sel;
    logic [1:0]  len;
    logic        no_advance;
    logic [16:0] ip_sum;
    logic [7:0]  op;
    logic [7:0]  b2;

    assign op  = instr.opcode;
    assign b2  = instr.second_byte;
    assign rm  = b2[2:0];
    assign sel = b2[5:3];

    always_comb begin
        gen_next   = gen_cur;
        seg_next   = seg_cur;
        ip_next    = ip_cur;
        count_next = count_cur;
        len        = 2'd1;
        no_advance = 1'b0;
        ip_sum     = '0;
        result     = '0;

        unique case (op) inside
            OP_ESCAPE: begin
                len = 2'd0;
                if (b2 >= ROM_SEL_LO && b2 <= ROM_SEL_HI) begin
                    result.service      = SVC_ROM;
                    result.service_code = b2 - ROM_SEL_LO;
                end else if (b2 == ROM_SEL_VIDEO) begin
                    result.service      = SVC_ROM;
                    result.service_code = ROM_CODE_VIDEO;
                end else begin
                    len = 2'd2;
                end
                if (result.service == SVC_ROM && result.service_code == ROM_CODE_HALT) begin
                    result.stop = STOP_HALT;
                    no_advance  = 1'b1;
                end
            end
            [OP_INC_LO:OP_INC_HI]: begin
                gen_next[op[2:0]] = gen_cur[op[2:0]] + 16'd1;
            end
            [OP_DEC_LO:OP_DEC_HI]: begin
                gen_next[op[2:0]] = gen_cur[op[2:0]] - 16'd1;
            end
            [OP_PUSH_LO:OP_PUSH_HI]: begin
                // The pushed value is read before SP moves, so PUSH SP stores the old SP.
                gen_next[REG_SP]     = gen_cur[REG_SP] - 16'd2;
                result.mem_write     = 1'b1;
                result.write_address = phys(seg_cur[SREG_SS], gen_cur[REG_SP] - 16'd2);
                result.write_data    = gen_cur[op[2:0]];
            end
            OP_MOV_FROM_SREG: begin
                len = 2'd2;
                if (b2[7:6] == MOD_REGISTER && !sel[2]) begin
                    gen_next[rm] = seg_cur[sel[1:0]];
                end
            end
            OP_MOV_TO_SREG: begin
                len = 2'd2;
                if (b2[7:6] == MOD_REGISTER && !sel[2]) begin
                    seg_next[sel[1:0]] = gen_cur[rm];
                end
            end
            [OP_MOV_IMM_LO:OP_MOV_IMM_HI]: begin
                len = 2'd3;
                gen_next[op[2:0]] = {instr.third_byte, b2};
            end
            OP_INT3: begin
                len                 = 2'd0;
                result.service      = SVC_INT;
                result.service_code = VECTOR_BREAK;
            end
            OP_INT: begin
                len                 = 2'd0;
                result.service      = SVC_INT;
                result.service_code = b2;
            end
            OP_IRET: begin
                len            = 2'd0;
                result.service = SVC_IRET;
            end
            OP_HLT: begin
                result.stop = STOP_HALT;
                no_advance  = 1'b1;
            end
            OP_GROUP5: begin
                len = 2'd2;
                if (b2[7:3] == GROUP5_JMP_REG) begin
                    ip_next = gen_cur[rm];
                    len     = 2'd0;
                end
            end
            default: begin
                len = 2'd1;
            end
        endcase

        if (!no_advance) begin
            ip_sum  = {1'b0, ip_next} + {15'd0, len};
            ip_next = ip_sum[15:0];
            // Running off the end of the offset moves the code segment up by 64 KiB.
            if (ip_sum[16]) begin
                seg_next[SREG_CS] = seg_next[SREG_CS] + SEG_WRAP;
            end
            if (instr.trap_flag) begin
                result.stop = STOP_TRAP;
            end else begin
                if (count_cur != COUNT_MAX) begin
                    count_next = count_cur + 16'd1;
                end
                if (count_next >= step_limit) begin
                    result.stop = STOP_LIMIT;
                end
            end
        end

        result.fetch_address = phys(seg_next[SREG_CS], ip_next);
    end

endmodule

// ===== design/real_mode_instruction_subset_step.sv =====
// Channel   Direction  Fields (low bit first)
// s_        in         opcode[7:0], second_byte[15:8], third_byte[23:16], trap_flag[24]
// m_        out        service, service_code, stop, mem_write, write_address,
//                      write_data, fetch_address (71 bits, zero pad to 72)
// cfg_wr_   in         step_limit[15:0], written at every edge where cfg_wr_en is high
//
// One instruction is executed per cycle while s_tready is high: decode and
// register-file update sit between the architectural registers and the result register,
// so a transfer can be taken on every clock. The result register is freed in the same
// cycle it is taken, so s_tready only drops while a result waits and m_tready is low.
// aresetn is synchronous, active low; it clears the general and segment registers,
// IP and the step count to zero and sets the step limit to 64.
module real_mode_instruction_subset_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode, second_byte, third_byte, trap_flag, 7 zero bits
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // service, service_code, stop, mem_write, write_address, write_data,
    // fetch_address, 1 zero bit
    output logic [71:0] m_tdata
);
    import rmis_pkg::*;

    gen_regs_t   gen_reg;
    gen_regs_t   gen_next;
    seg_regs_t   seg_reg;
    seg_regs_t   seg_next;
    logic [15:0] ip_reg;
    logic [15:0] ip_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] step_limit_reg;
    logic        m_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    instr_t      instr;
    logic        s_fire;

    assign instr.opcode      = s_tdata[7:0];
    assign instr.second_byte = s_tdata[15:8];
    assign instr.third_byte  = s_tdata[23:16];
    assign instr.trap_flag   = s_tdata[24];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, result_reg.fetch_address, result_reg.write_data,
                       result_reg.write_address, result_reg.mem_write, result_reg.stop,
                       result_reg.service_code, result_reg.service};

    rmis_exec u_exec (
        .instr      (instr),
        .gen_cur    (gen_reg),
        .seg_cur    (seg_reg),
        .ip_cur     (ip_reg),
        .count_cur  (count_reg),
        .step_limit (step_limit_reg),
        .gen_next   (gen_next),
        .seg_next   (seg_next),
        .ip_next    (ip_next),
        .count_next (count_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg        <= '{default: 16'd0};
            seg_reg        <= '{default: 16'd0};
            ip_reg         <= '0;
            count_reg      <= '0;
            step_limit_reg <= STEP_LIMIT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                step_limit_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                gen_reg     <= gen_next;
                seg_reg     <= seg_next;
                ip_reg      <= ip_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== dv/rmis_step_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the step-limit write port, keeps its own copy of
// the architectural state and compares every result transfer in order.
module rmis_step_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          mismatches,
    output int          awaited,
    output int          results_checked
);
    import rmis_pkg::*;

    logic [15:0] gpr [8];
    logic [15:0] sreg [4];
    logic [15:0] ip_reg;
    logic [15:0] steps;
    logic [15:0] limit;

    result_t predicted_results [$];
    int fail_count;
    int checked_count;

    function automatic logic [20:0] seg_addr(input logic [15:0] seg, input logic [15:0] off);
        return {1'b0, seg, 4'b0000} + {5'b00000, off};
    endfunction

    // Executes one instruction on the local state and returns what the block must report.
    function automatic result_t execute_instr(input instr_t ins);
        result_t     r;
        logic [7:0]  op;
        logic [7:0]  b2;
        logic [2:0]  sel;
        logic [2:0]  rm;
        logic [15:0] pushed;
        logic [1:0]  len;
        logic        hold_ip;
        logic [16:0] next_ip;
        r = '0;
        r.service = SVC_NONE;
        r.stop = STOP_RUN;
        op = ins.opcode;
        b2 = ins.second_byte;
        sel = b2[5:3];
        rm = b2[2:0];
        len = 2'd1;
        hold_ip = 1'b0;
        if (op == OP_ESCAPE) begin
            len = 2'd0;
            if (b2 >= ROM_SEL_LO && b2 <= ROM_SEL_HI) begin
                r.service = SVC_ROM;
                r.service_code = b2 - ROM_SEL_LO;
            end else if (b2 == ROM_SEL_VIDEO) begin
                r.service = SVC_ROM;
                r.service_code = ROM_CODE_VIDEO;
            end else begin
                len = 2'd2;
            end
            if (r.service == SVC_ROM && r.service_code == ROM_CODE_HALT) begin
                r.stop = STOP_HALT;
                hold_ip = 1'b1;
            end
        end else if (op >= OP_INC_LO && op <= OP_INC_HI) begin
            gpr[op[2:0]] = gpr[op[2:0]] + 16'd1;
        end else if (op >= OP_DEC_LO && op <= OP_DEC_HI) begin
            gpr[op[2:0]] = gpr[op[2:0]] - 16'd1;
        end else if (op >= OP_PUSH_LO && op <= OP_PUSH_HI) begin
            // The value is read before SP moves, so PUSH SP stores the old SP.
            pushed = gpr[op[2:0]];
            gpr[REG_SP] = gpr[REG_SP] - 16'd2;
            r.mem_write = 1'b1;
            r.write_address = seg_addr(sreg[SREG_SS], gpr[REG_SP]);
            r.write_data = pushed;
        end else if (op == OP_MOV_FROM_SREG) begin
            len = 2'd2;
            if (b2[7:6] == MOD_REGISTER && !sel[2]) begin
                gpr[rm] = sreg[sel[1:0]];
            end
        end else if (op == OP_MOV_TO_SREG) begin
            len = 2'd2;
            if (b2[7:6] == MOD_REGISTER && !sel[2]) begin
                sreg[sel[1:0]] = gpr[rm];
            end
        end else if (op >= OP_MOV_IMM_LO && op <= OP_MOV_IMM_HI) begin
            len = 2'd3;
            gpr[op[2:0]] = {ins.third_byte, b2};
        end else if (op == OP_INT3) begin
            len = 2'd0;
            r.service = SVC_INT;
            r.service_code = VECTOR_BREAK;
        end else if (op == OP_INT) begin
            len = 2'd0;
            r.service = SVC_INT;
            r.service_code = b2;
        end else if (op == OP_IRET) begin
            len = 2'd0;
            r.service = SVC_IRET;
        end else if (op == OP_HLT) begin
            r.stop = STOP_HALT;
            hold_ip = 1'b1;
        end else if (op == OP_GROUP5) begin
            len = 2'd2;
            if (b2[7:3] == GROUP5_JMP_REG) begin
                ip_reg = gpr[rm];
                len = 2'd0;
            end
        end

        if (!hold_ip) begin
            // A carry out of IP moves the code segment on by 64 KiB.
            next_ip = {1'b0, ip_reg} + {15'd0, len};
            if (next_ip[16]) begin
                sreg[SREG_CS] = sreg[SREG_CS] + SEG_WRAP;
            end
            ip_reg = next_ip[15:0];
            if (ins.trap_flag) begin
                r.stop = STOP_TRAP;
            end else begin
                if (steps != COUNT_MAX) begin
                    steps = steps + 16'd1;
                end
                if (steps >= limit) begin
                    r.stop = STOP_LIMIT;
                end
            end
        end
        r.fetch_address = seg_addr(sreg[SREG_CS], ip_reg);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [20:0] want,
                                        input logic [20:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        instr_t  ins;
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) gpr[i] = '0;
            for (int i = 0; i < 4; i++) sreg[i] = '0;
            ip_reg = '0;
            steps = '0;
            limit = STEP_LIMIT_RESET;
            predicted_results.delete();
        end else begin
            // A result is registered before it leaves, so its instruction was taken at an earlier
            // edge; the result side is settled before this edge's instruction is added.
            if (m_tvalid && m_tready) begin
                got.service = service_t'(m_tdata[1:0]);
                got.service_code = m_tdata[9:2];
                got.stop = stop_t'(m_tdata[11:10]);
                got.mem_write = m_tdata[12];
                got.write_address = m_tdata[33:13];
                got.write_data = m_tdata[49:34];
                got.fetch_address = m_tdata[70:50];
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual 0x%0h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("service", 21'(want.service), 21'(got.service));
                    check_field("service_code", 21'(want.service_code), 21'(got.service_code));
                    check_field("stop", 21'(want.stop), 21'(got.stop));
                    check_field("mem_write", 21'(want.mem_write), 21'(got.mem_write));
                    check_field("write_address", want.write_address, got.write_address);
                    check_field("write_data", 21'(want.write_data), 21'(got.write_data));
                    check_field("fetch_address", want.fetch_address, got.fetch_address);
                    checked_count++;
                end
            end
            if (cfg_wr_en) begin
                limit = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                ins.opcode = s_tdata[7:0];
                ins.second_byte = s_tdata[15:8];
                ins.third_byte = s_tdata[23:16];
                ins.trap_flag = s_tdata[24];
                predicted_results.push_back(execute_instr(ins));
            end
        end
        mismatches <= fail_count;
        awaited <= predicted_results.size();
        results_checked <= checked_count;
    end

endmodule

// ===== dv/real_mode_instruction_subset_step_tb.sv =====
`timescale 1ns / 1ps

module real_mode_instruction_subset_step_tb;
    import rmis_pkg::*;

    localparam logic [7:0] OP_NOP = 8'h90;
    localparam logic [2:0] REG_AX = 3'd0;
    localparam logic [2:0] REG_CX = 3'd1;
    localparam logic [2:0] REG_DX = 3'd2;
    localparam logic [2:0] REG_BX = 3'd3;
    localparam logic [2:0] REG_DI = 3'd7;
    localparam logic [2:0] SREG_UNUSED_LO = 3'd4;
    localparam logic [2:0] SREG_UNUSED_HI = 3'd7;
    localparam logic [1:0] MOD_MEMORY = 2'b00;

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum int {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } idle_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    // opcode, second_byte, third_byte, trap_flag, 7 zero bits
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // service, service_code, stop, mem_write, write_address, write_data,
    // fetch_address, 1 zero bit
    logic [71:0] m_tdata;

    int         mismatches;
    int         pending;
    int         checked;
    int         sent;
    idle_mode_t idle_mode;
    bit         hold_output;

    real_mode_instruction_subset_step dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    rmis_step_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .awaited         (pending),
        .results_checked (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int draw_gap();
        case (idle_mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 14);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        endcase
    endfunction

    function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                         input logic [2:0] rm);
        return {md, rg, rm};
    endfunction

    function automatic instr_t mk_instr(input logic [7:0] op, input logic [7:0] b2,
                                        input logic [7:0] b3, input logic tf);
        instr_t ins;
        ins.opcode = op;
        ins.second_byte = b2;
        ins.third_byte = b3;
        ins.trap_flag = tf;
        return ins;
    endfunction

    // Mostly well-formed instructions with random operands, plus raw byte noise.
    function automatic instr_t random_instr();
        instr_t ins;
        logic [7:0] rom_sel;
        ins.opcode = 8'($urandom_range(0, 255));
        ins.second_byte = 8'($urandom_range(0, 255));
        ins.third_byte = 8'($urandom_range(0, 255));
        ins.trap_flag = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 19))
            0, 1: ins.opcode = OP_INC_LO + 8'($urandom_range(0, 7));
            2, 3: ins.opcode = OP_DEC_LO + 8'($urandom_range(0, 7));
            4, 5: ins.opcode = OP_PUSH_LO + 8'($urandom_range(0, 7));
            6, 7, 8: ins.opcode = OP_MOV_IMM_LO + 8'($urandom_range(0, 7));
            9, 10: begin
                ins.opcode = ($urandom_range(0, 1) == 0) ? OP_MOV_FROM_SREG : OP_MOV_TO_SREG;
                if ($urandom_range(0, 3) != 0) begin
                    ins.second_byte = modrm(MOD_REGISTER, 3'($urandom_range(0, 3)),
                                            3'($urandom_range(0, 7)));
                end
            end
            11: begin
                ins.opcode = OP_GROUP5;
                if ($urandom_range(0, 3) != 0) begin
                    ins.second_byte = {GROUP5_JMP_REG, 3'($urandom_range(0, 7))};
                end
            end
            12: ins.opcode = ($urandom_range(0, 3) == 0) ? OP_INT3 : OP_INT;
            13: ins.opcode = OP_IRET;
            14: begin
                ins.opcode = OP_ESCAPE;
                rom_sel = ROM_SEL_LO + 8'($urandom_range(0, 4));
                case ($urandom_range(0, 3))
                    0:       ins.second_byte = ROM_SEL_VIDEO;
                    1:       ins.second_byte = ins.second_byte;
                    default: ins.second_byte = rom_sel;
                endcase
            end
            15: ins.opcode = OP_HLT;
            default: ins.opcode = ins.opcode;
        endcase
        return ins;
    endfunction

    task automatic send_instr(input instr_t ins);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, ins.trap_flag, ins.third_byte, ins.second_byte, ins.opcode};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // The limit is only changed once every outstanding result has been taken.
    task automatic write_limit(input logic [15:0] value);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (2) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_directed();
        idle_mode = IDLE_SPARSE;
        send_instr(mk_instr(OP_MOV_IMM_LO + 8'(REG_AX), 8'hFF, 8'hFF, 1'b0));
        send_instr(mk_instr(OP_MOV_TO_SREG, modrm(MOD_REGISTER, {1'b0, SREG_SS}, REG_AX),
                            8'h00, 1'b0));
        send_instr(mk_instr(OP_DEC_LO + 8'(REG_DI), 8'h00, 8'h00, 1'b0));
        send_instr(mk_instr(OP_PUSH_LO + 8'(REG_DI), 8'h00, 8'h00, 1'b0));
        send_instr(mk_instr(OP_PUSH_LO + 8'(REG_SP), 8'hFF, 8'hFF, 1'b0));
        send_instr(mk_instr(OP_INC_LO + 8'(REG_AX), 8'h00, 8'h00, 1'b0));
        send_instr(mk_instr(OP_MOV_FROM_SREG, modrm(MOD_REGISTER, {1'b0, SREG_SS}, REG_CX),
                            8'h00, 1'b0));
        // Memory operand and segment indexes above DS leave the registers alone.
        send_instr(mk_instr(OP_MOV_TO_SREG, modrm(MOD_MEMORY, {1'b0, SREG_CS}, REG_AX),
                            8'h00, 1'b0));
        send_instr(mk_instr(OP_MOV_TO_SREG, modrm(MOD_REGISTER, SREG_UNUSED_LO, REG_AX),
                            8'h00, 1'b0));
        send_instr(mk_instr(OP_MOV_FROM_SREG, modrm(MOD_REGISTER, SREG_UNUSED_HI, REG_DX),
                            8'h00, 1'b0));
        send_instr(mk_instr(OP_ESCAPE, ROM_SEL_LO, 8'h00, 1'b0));
        send_instr(mk_instr(OP_ESCAPE, ROM_SEL_LO + ROM_CODE_HALT, 8'h00, 1'b0));
        send_instr(mk_instr(OP_ESCAPE, ROM_SEL_HI, 8'h00, 1'b0));
        send_instr(mk_instr(OP_ESCAPE, ROM_SEL_VIDEO, 8'h00, 1'b0));
        send_instr(mk_instr(OP_ESCAPE, 8'h00, 8'h00, 1'b0));
        send_instr(mk_instr(OP_ESCAPE, 8'hFF, 8'hFF, 1'b0));
        send_instr(mk_instr(OP_INT3, 8'h00, 8'h00, 1'b0));
        send_instr(mk_instr(OP_INT, 8'hFF, 8'h00, 1'b0));
        send_instr(mk_instr(OP_INT, 8'h00, 8'h00, 1'b0));
        send_instr(mk_instr(OP_IRET, 8'h00, 8'h00, 1'b0));
        send_instr(mk_instr(OP_HLT, 8'h00, 8'h00, 1'b0));
        send_instr(mk_instr(OP_NOP, 8'h00, 8'h00, 1'b1));
        // Jump to the top of the segment, then let a three-byte move carry IP over.
        send_instr(mk_instr(OP_MOV_IMM_LO + 8'(REG_BX), 8'hFE, 8'hFF, 1'b0));
        send_instr(mk_instr(OP_GROUP5, {GROUP5_JMP_REG, REG_BX}, 8'h00, 1'b0));
        send_instr(mk_instr(OP_MOV_IMM_LO + 8'(REG_CX), 8'h34, 8'h12, 1'b0));
        send_instr(mk_instr(OP_GROUP5, 8'h00, 8'h00, 1'b0));
    endtask

    task automatic run_random(input int count, input bit with_hold);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                idle_mode = idle_mode_t'($urandom_range(0, 2));
            end
            if (with_hold && i == 20) begin
                idle_mode = IDLE_NONE;
                hold_output = 1'b1;
            end
            send_instr(random_instr());
        end
    endtask

    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** real_mode_instruction_subset_step: FAILED **");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        idle_mode = IDLE_NONE;
        hold_output = 1'b0;
        sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_limit(16'd20);
        run_directed();
        write_limit(16'd250);
        run_random(150, 1'b1);
        write_limit(16'd1);
        run_random(100, 1'b0);
        write_limit(16'd0);
        run_random(100, 1'b0);
        write_limit(16'd600);
        run_random(150, 1'b0);
        write_limit(16'hFFFF);
        run_random(125, 1'b0);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run summary: %0d instructions sent, %0d results checked, %0d mismatches.",
                 sent, checked, mismatches);
        $display("Covered all opcode groups, IP carry into CS, pushes, service calls, stops,");
        $display("and step limits 0, 1, 20, 250, 600 and 65535 under random stalls.");
        if (mismatches == 0) begin
            $display("** real_mode_instruction_subset_step: PASSED **");
        end else begin
            $display("** real_mode_instruction_subset_step: FAILED **");
        end
        $finish;
    end

endmodule
